// ===== rtl/assert_macros.svh =====
// assertion macros shared by the room service dispatcher modules
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk_s, rst_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr)

`endif

`endif

// ===== rtl/rsd_pkg.sv =====
// shared types and constants of the room service slot dispatcher
// no dependencies; imported by every rsd module
package rsd_pkg;

  localparam int SLOTS            = 6;
  localparam int TIME_BITS        = 16;
  localparam int SLOT_W           = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W            = $clog2(SLOTS + 1);
  localparam int MAXS_W           = 3;
  localparam int RANK_W           = (CNT_W > MAXS_W) ? CNT_W : MAXS_W;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  // fixed field widths of the stream words
  localparam int FUNC_W           = 2;
  localparam int SLOT_IN_W        = 3;
  localparam int FAN_W            = 2;
  localparam int TIME_IN_W        = 16;
  localparam int MASK_W           = 6;
  localparam int IN_DATA_W        = 24;
  localparam int OUT_DATA_W       = 8;

  localparam logic [MAXS_W-1:0] MAX_SERVED_RESET = 3'd3;

  localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PRIORITY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROTATE   = 2'd2;

  typedef enum logic [1:0] {
    CMD_UPDATE,
    CMD_PRIORITY,
    CMD_ROTATE,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [SLOT_W-1:0]      slot;
    logic                   connected;
    logic                   powered;
    logic [FAN_W-1:0]       fan_speed;
    logic [TIME_BITS-1:0]   served_time;
  } cmd_t;

endpackage

// ===== rtl/room_service_slot_dispatcher.sv =====
// top level of the room service slot dispatcher
// depends on rsd_pkg, rsd_front, rsd_queue and rsd_back
// usage:
//   s_axis carries one command word: tuser is func (update, priority dispatch,
//   rotating dispatch), tdata packs slot, connected, powered, fan_speed and
//   served_time. m_axis returns one word per command: the in-service mask of
//   all slots after that command, bit i for slot i.
//   max_served is written through max_served_we / max_served_wdata while idle.
// flow and throughput:
//   an accepted word lands in a two-entry queue; the back end takes it when
//   idle with a free result register and registers the result: for update,
//   rotate and no-op words as it takes the word, for priority dispatch after
//   first registering the pairwise ranking, then the rank count.
//   update and rotate run at one word per cycle while m_axis_tready stays high;
//   priority dispatch takes no new word until its rank result is loaded.
// reset: clears the queue and all connected and in-service flags, max_served to 3
// stalls:
//   while m_axis_tready is low the result word is held; the queue keeps
//   taking words until its two entries are full, then s_axis_tready drops.
module room_service_slot_dispatcher
  import rsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   max_served_we,
  input  logic [MAXS_W-1:0]      max_served_wdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // slot, connected, powered, fan_speed, served_time
  input  logic [FUNC_W-1:0]      s_axis_tuser,   // func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata    // in_service_mask
);

  logic [MAXS_W-1:0] max_served;   // configuration register
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  cmd_t              front_cmd;
  cmd_t              q_cmd;
  logic [MASK_W-1:0] mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_served <= MAX_SERVED_RESET;
    end else if (max_served_we) begin
      max_served <= max_served_wdata;
    end
  end

  // decode stage: func and slot range check
  rsd_front u_front (
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .push          (q_push),
    .cmd           (front_cmd)
  );

  // decouples decode from execution
  rsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_cmd   (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  // slot table and dispatch logic with the result register
  rsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_served    (max_served),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .out_mask      (mask)
  );

  // pad the mask to a whole byte
  assign m_axis_tdata = {{(OUT_DATA_W - MASK_W){1'b0}}, mask};

endmodule

// ===== rtl/rsd_front.sv =====
// front end: takes input words, decodes func and slot into a command
// depends on rsd_pkg; feeds rsd_queue
module rsd_front
  import rsd_pkg::*;
(
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // slot, connected, powered, fan_speed, served_time
  input  logic [FUNC_W-1:0]     s_axis_tuser,  // func
  input  logic                  q_full,
  output logic                  push,
  output cmd_t                  cmd
);

  logic [SLOT_IN_W-1:0] in_slot;
  logic                 slot_ok;

  assign in_slot       = s_axis_tdata[2:0];
  assign slot_ok       = (32'(in_slot) < SLOTS);
  assign s_axis_tready = !q_full && !rst;
  assign push          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.slot        = SLOT_W'(in_slot);
    cmd.connected   = s_axis_tdata[3];
    cmd.powered     = s_axis_tdata[4];
    cmd.fan_speed   = s_axis_tdata[6:5];
    cmd.served_time = TIME_BITS'(s_axis_tdata[22:7]);
    case (s_axis_tuser)
      FUNC_UPDATE:   cmd.kind = slot_ok ? CMD_UPDATE : CMD_NOP;
      FUNC_PRIORITY: cmd.kind = CMD_PRIORITY;
      FUNC_ROTATE:   cmd.kind = CMD_ROTATE;
      default:       cmd.kind = CMD_NOP;
    endcase
  end

endmodule

// ===== rtl/rsd_queue.sv =====
// short command queue between front and back end
// depends on rsd_pkg and assert_macros.svh
`include "assert_macros.svh"
module rsd_queue
  import rsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  cmd_t  wr_cmd,
  output logic  full,
  input  logic  pop,
  output logic  rd_valid,
  output cmd_t  rd_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= wr_cmd;
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && !rd_valid)
  `ASSERT_CLK(a_count_grows, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1))

endmodule

// ===== rtl/rsd_back.sv =====
// back end: slot table, dispatch ranking and rotation, result register
// depends on rsd_pkg and assert_macros.svh
`include "assert_macros.svh"
module rsd_back
  import rsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [MAXS_W-1:0]      max_served,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [MASK_W-1:0]      out_mask
);

  typedef enum logic {S_IDLE, S_RANK} state_t;

  state_t               state;
  logic [SLOTS-1:0]     conn;
  logic [SLOTS-1:0]     pw;
  logic [FAN_W-1:0]     fan  [SLOTS];
  logic [TIME_BITS-1:0] tm   [SLOTS];
  logic [SLOTS-1:0]     svc;
  logic [SLOTS-1:0]     beat [SLOTS];   // beat[i][j]: connected slot j outranks slot i

  logic [SLOTS-1:0]     beat_next [SLOTS];
  logic [SLOTS-1:0]     rot_next;
  logic [SLOTS-1:0]     pri_next;
  logic [SLOTS-1:0]     upd_svc;
  logic [RANK_W-1:0]    pw_cnt;
  logic                 can_out;
  logic                 apply_pri;
  logic                 out_load;

  function automatic logic beats(input logic pa, input logic pb,
                                 input logic [FAN_W-1:0] fa, input logic [FAN_W-1:0] fb,
                                 input logic [TIME_BITS-1:0] ta,
                                 input logic [TIME_BITS-1:0] tb, input logic a_low);
    logic r;
    if (pa != pb)      r = pa;
    else if (fa != fb) r = (fa > fb);
    else if (ta != tb) r = (ta < tb);
    else               r = a_low;
    return r;
  endfunction

  function automatic logic [MASK_W-1:0] to_mask(input logic [SLOTS-1:0] v);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if (k < SLOTS) m[k] = v[k];
    end
    return m;
  endfunction

  assign can_out   = !m_axis_tvalid || m_axis_tready;
  assign pop       = (state == S_IDLE) && q_valid && can_out;
  assign apply_pri = (state == S_RANK) && can_out;
  // a result word is loaded this cycle
  assign out_load  = (pop && (q_cmd.kind != CMD_PRIORITY)) || apply_pri;

  // pairwise ranking, registered before the count
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      for (int j = 0; j < SLOTS; j++) begin
        beat_next[i][j] = (j != i) && conn[j] &&
                          beats(pw[j], pw[i], fan[j], fan[i], tm[j], tm[i], j < i);
      end
    end
  end

  // rank count against max_served
  always_comb begin
    logic [RANK_W-1:0] rank;
    for (int i = 0; i < SLOTS; i++) begin
      rank = '0;
      for (int j = 0; j < SLOTS; j++) begin
        rank = rank + RANK_W'(beat[i][j]);
      end
      pri_next[i] = conn[i] ? (rank < RANK_W'(max_served)) : svc[i];
    end
  end

  // ascending rotation over connected slots, or all powered set if <= max_served
  always_comb begin
    logic nxt;
    pw_cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pw_cnt = pw_cnt + RANK_W'(pw[i] & conn[i]);
    end
    for (int i = 0; i < SLOTS; i++) begin
      nxt = svc[i];
      for (int d = SLOTS - 1; d >= 1; d--) begin
        if (conn[(i + d) % SLOTS]) nxt = svc[(i + d) % SLOTS];
      end
      rot_next[i] = conn[i] ? nxt : svc[i];
    end
    if (pw_cnt <= RANK_W'(max_served)) begin
      rot_next = svc | (conn & pw);
    end
  end

  assign upd_svc = svc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      conn          <= '0;
      svc           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && !out_load) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (q_cmd.kind)
              CMD_UPDATE: begin
                conn[q_cmd.slot] <= q_cmd.connected;
                pw[q_cmd.slot]   <= q_cmd.powered;
                fan[q_cmd.slot]  <= q_cmd.fan_speed;
                tm[q_cmd.slot]   <= q_cmd.served_time;
                m_axis_tvalid    <= 1'b1;
                out_mask         <= to_mask(upd_svc);
              end
              CMD_PRIORITY: begin
                beat  <= beat_next;
                state <= S_RANK;
              end
              CMD_ROTATE: begin
                svc           <= rot_next;
                m_axis_tvalid <= 1'b1;
                out_mask      <= to_mask(rot_next);
              end
              default: begin
                m_axis_tvalid <= 1'b1;
                out_mask      <= to_mask(svc);
              end
            endcase
          end
        end
        S_RANK: begin
          if (apply_pri) begin
            svc           <= pri_next;
            m_axis_tvalid <= 1'b1;
            out_mask      <= to_mask(pri_next);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_served_limit, clk, rst, apply_pri |=> ($countones(svc & conn) <= max_served))

endmodule

// ===== tb/sv/rsd_service_mask_checker.sv =====
// checker for the room service slot dispatcher: keeps its own slot table,
// works out the in-service mask for each accepted command word and compares
// depends on rsd_pkg
module rsd_service_mask_checker
  import rsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  max_served_we,
  input  logic [MAXS_W-1:0]     max_served_wdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    mismatch_count,
  output int                    masks_pending
);

  logic                 slot_conn [SLOTS];
  logic                 slot_pwr  [SLOTS];
  logic [FAN_W-1:0]     slot_fan  [SLOTS];
  logic [TIME_BITS-1:0] slot_time [SLOTS];
  logic                 slot_busy [SLOTS];
  logic [MAXS_W-1:0]    serve_limit;
  logic [MASK_W-1:0]    mask_q [$];

  // powered, then faster fan, then shorter served time, then lower index
  function automatic bit outranks(int a, int b);
    if (slot_pwr[a] != slot_pwr[b]) return slot_pwr[a];
    if (slot_fan[a] != slot_fan[b]) return slot_fan[a] > slot_fan[b];
    if (slot_time[a] != slot_time[b]) return slot_time[a] < slot_time[b];
    return a < b;
  endfunction

  task automatic rank_dispatch();
    logic nxt [SLOTS];
    int   beaten;
    for (int i = 0; i < SLOTS; i++) begin
      nxt[i] = slot_busy[i];
      if (slot_conn[i]) begin
        beaten = 0;
        for (int j = 0; j < SLOTS; j++)
          if (j != i && slot_conn[j] && outranks(j, i)) beaten++;
        nxt[i] = (beaten < serve_limit);
      end
    end
    for (int i = 0; i < SLOTS; i++) slot_busy[i] = nxt[i];
  endtask

  task automatic rotate_dispatch();
    int   order [SLOTS];
    logic old   [SLOTS];
    int   n;
    int   powered_cnt;
    n = 0;
    powered_cnt = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_conn[i]) begin
        order[n] = i;
        old[n]   = slot_busy[i];
        n++;
        if (slot_pwr[i]) powered_cnt++;
      end
    end
    if (powered_cnt <= serve_limit) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_conn[i] && slot_pwr[i]) slot_busy[i] = 1'b1;
    end else begin
      for (int i = 0; i < n; i++) slot_busy[order[i]] = old[(i + 1) % n];
    end
  endtask

  task automatic apply_word(input logic [FUNC_W-1:0] func, input logic [IN_DATA_W-1:0] data);
    logic [SLOT_IN_W-1:0] s;
    s = data[SLOT_IN_W-1:0];
    case (cmd_kind_t'(func))
      CMD_UPDATE: begin
        // slots past the table are dropped
        if (s < SLOTS) begin
          slot_conn[s] = data[3];
          slot_pwr[s]  = data[4];
          slot_fan[s]  = data[6:5];
          slot_time[s] = data[7 +: TIME_IN_W];
        end
      end
      CMD_PRIORITY: rank_dispatch();
      CMD_ROTATE:   rotate_dispatch();
      default: ;
    endcase
  endtask

  function automatic logic [MASK_W-1:0] service_mask();
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < SLOTS; i++) m[i] = slot_busy[i];
    return m;
  endfunction

  always @(posedge clk) begin
    logic [MASK_W-1:0] want;
    logic [MASK_W-1:0] got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_conn[i] = 1'b0;
        slot_pwr[i]  = 1'b0;
        slot_fan[i]  = '0;
        slot_time[i] = '0;
        slot_busy[i] = 1'b0;
      end
      serve_limit = MAX_SERVED_RESET;
      mask_q.delete();
    end else begin
      if (max_served_we) serve_limit = max_served_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[MASK_W-1:0];
        if (mask_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result word: mask %b", got);
        end else begin
          want = mask_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("in_service_mask mismatch: expected %b, got %b", want, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_word(s_axis_tuser, s_axis_tdata);
        mask_q.push_back(service_mask());
      end
    end
    masks_pending <= mask_q.size();
  end

endmodule

// ===== tb/sv/room_service_slot_dispatcher_tb.sv =====
// testbench top for the room service slot dispatcher: clock, reset, command
// stimulus, result back-pressure, watchdog and verdict
// depends on rsd_pkg, rsd_service_mask_checker and the dispatcher rtl
module room_service_slot_dispatcher_tb;
  import rsd_pkg::*;

  // cycles with no word moving on either side before the run is abandoned
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  max_served_we = 1'b0;
  logic [MAXS_W-1:0]     max_served_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // slot, connected, powered, fan_speed, served_time
  logic [FUNC_W-1:0]     s_axis_tuser = '0;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // in_service_mask

  int mismatch_count;
  int masks_pending;
  bit idle_on;      // random bursts of idling allowed on both sides
  int rx_hold;
  int quiet_cycles;

  // period of 4 units
  always #2 clk = ~clk;

  room_service_slot_dispatcher DUT (
    .clk              (clk),
    .rst              (rst),
    .max_served_we    (max_served_we),
    .max_served_wdata (max_served_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata)
  );

  rsd_service_mask_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .max_served_we    (max_served_we),
    .max_served_wdata (max_served_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count   (mismatch_count),
    .masks_pending    (masks_pending)
  );

  // result side back-pressure: when idling is allowed, tready is dropped in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog: counts cycles in which no word is accepted on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one command word, after an optional idle burst, and hold it
  // until the edge at which it is taken
  task automatic send_word(input cmd_kind_t kind, input logic [SLOT_IN_W-1:0] slot,
                           input logic conn, input logic pwr,
                           input logic [FAN_W-1:0] fan, input logic [TIME_IN_W-1:0] t);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    // packed from bit 0: slot, connected, powered, fan_speed, served_time, pad
    s_axis_tdata  <= {1'b0, t, fan, pwr, conn, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // a random command word; served times lean towards small values so that
  // ranking ties on time are frequent, slot indexes past the table are rare
  task automatic send_random_word();
    cmd_kind_t                kind;
    int                       pick;
    logic [SLOT_IN_W-1:0]     slot;
    logic [TIME_IN_W-1:0]     t;
    pick = $urandom_range(0, 99);
    kind = (pick < 55) ? CMD_UPDATE : (pick < 75) ? CMD_PRIORITY :
           (pick < 95) ? CMD_ROTATE : CMD_NOP;
    if ($urandom_range(0, 15) == 0) slot = SLOT_IN_W'($urandom_range(SLOTS, 7));
    else                            slot = SLOT_IN_W'($urandom_range(0, SLOTS - 1));
    case ($urandom_range(0, 3))
      0:       t = TIME_IN_W'($urandom_range(0, 3));
      1:       t = TIME_IN_W'($urandom);
      2:       t = $urandom_range(0, 1) ? {TIME_IN_W{1'b1}} : {TIME_IN_W{1'b0}};
      default: t = TIME_IN_W'($urandom_range(0, 255));
    endcase
    send_word(kind, slot, $urandom_range(0, 3) != 0, $urandom_range(0, 2) != 0,
              FAN_W'($urandom_range(0, 3)), t);
  endtask

  // stop sending and wait until every expected mask has come back, then let
  // the clock run on so the pipeline is surely empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (masks_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // the register is only written while the dispatcher is idle
  task automatic write_max_served(input logic [MAXS_W-1:0] v);
    max_served_we    <= 1'b1;
    max_served_wdata <= v;
    @(posedge clk);
    max_served_we    <= 1'b0;
  endtask

  initial begin
    logic [MAXS_W-1:0] limits [8];
    limits = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd5, 3'd4, 3'd3};
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, max_served at its reset value of three
    send_word(CMD_NOP,      0, 0, 0, 0, 0);            // no-op straight after reset
    send_word(CMD_PRIORITY, 0, 0, 0, 0, 0);            // dispatch with no slot connected
    send_word(CMD_ROTATE,   0, 0, 0, 0, 0);
    send_word(CMD_UPDATE,   0, 1, 1, 3, 16'h0000);
    send_word(CMD_UPDATE,   1, 1, 1, 3, 16'h0000);     // full tie with slot 0, index decides
    send_word(CMD_UPDATE,   2, 1, 0, 3, 16'hFFFF);     // unpowered, fastest fan
    send_word(CMD_UPDATE,   3, 1, 1, 0, 16'hFFFF);
    send_word(CMD_UPDATE,   4, 1, 1, 2, 16'd100);
    send_word(CMD_UPDATE,   5, 1, 1, 2, 16'd99);      // shorter time beats slot 4
    send_word(CMD_UPDATE,   6, 1, 1, 3, 16'hFFFF);     // past the table, dropped
    send_word(CMD_UPDATE,   7, 1, 1, 3, 16'hFFFF);
    send_word(CMD_PRIORITY, 0, 0, 0, 0, 0);
    send_word(CMD_ROTATE,   0, 0, 0, 0, 0);            // five powered, so flags rotate
    send_word(CMD_ROTATE,   0, 0, 0, 0, 0);
    send_word(CMD_UPDATE,   2, 0, 0, 0, 0);
    send_word(CMD_UPDATE,   3, 1, 0, 1, 16'd5);
    send_word(CMD_UPDATE,   4, 1, 0, 1, 16'd5);
    send_word(CMD_ROTATE,   0, 0, 0, 0, 0);            // three powered, all granted
    send_word(CMD_PRIORITY, 0, 0, 0, 0, 0);
    send_word(CMD_NOP,      7, 1, 1, 3, 16'hFFFF);
    send_word(CMD_UPDATE,   0, 0, 1, 3, 16'h0000);     // unconnected slot keeps its flag
    send_word(CMD_PRIORITY, 0, 0, 0, 0, 0);
    drain();

    // random phases, one per max_served setting, extremes first; each phase
    // ends with the sender waiting for every result, the last without idling
    for (int p = 0; p < 8; p++) begin
      write_max_served(limits[p]);
      for (int k = 0; k < 120; k++) begin
        if (k % 40 == 0) idle_on = (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
        send_random_word();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && masks_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
